@@ sv/bmhq_pkg.sv @@
// ----------------------------------------------------------------------------
// bmhq_pkg - shared types and codes for the max priority queue
// Transfer structs, operation and status codes, cell slot type.
// ----------------------------------------------------------------------------
package bmhq_pkg;

	localparam int VALUE_W = 32;
	localparam int ENTRY_W = 7;

	// operation codes (req.kind)
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// status codes (rsp.status)
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                      kind;
		logic signed [VALUE_W-1:0] value;
	} bmhq_req_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [VALUE_W-1:0] removed_value;
		logic signed [VALUE_W-1:0] top_value;
		logic [ENTRY_W-1:0]        entry_count;
	} bmhq_rsp_t;

	// one stored entry as held by a cell and handed to its neighbors
	typedef struct packed {
		logic                      valid;
		logic signed [VALUE_W-1:0] value;
	} bmhq_slot_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic                      ins;
		logic                      rem;
		logic signed [VALUE_W-1:0] value;
	} bmhq_ctrl_t;

endpackage

@@ sv/binary_max_heap_queue_unit.sv @@
// ----------------------------------------------------------------------------
// binary_max_heap_queue_unit - max priority queue on a chain of cells
// Insert and remove-max over signed 32-bit values, one result per request.
// ----------------------------------------------------------------------------
//
//  channel   ports              transfer when
//  --------  -----------------  ----------------------------
//  request   start, busy, req   start high and busy low
//  result    done, rsp          done high (one cycle, no stall)
//
//  The accept edge captures a request in the request register; the next edge
//  updates every cell of the chain at once and registers the result, which
//  shows on rsp with done for one cycle. busy is high in the update cycle,
//  so no new request is taken while one is being applied to the chain.
//  Reset clears the count, the cell valid bits and the request and result
//  strobes; the queue is empty afterwards and no clearing pass is needed.
//  The receiver cannot stall: a result is gone after its done cycle.
//
module binary_max_heap_queue_unit
	import bmhq_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  bmhq_req_t req,
	output logic      done,
	output bmhq_rsp_t rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	// The chain is kept sorted, largest entry in cell 0, empty cells at the
	// tail. Results depend only on the set of stored values, so this answers
	// exactly as a binary heap would.

	// request register: keeps the broadcast to all cells off the input pins
	logic      req_vld_s1;
	bmhq_req_t req_s1;

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	bmhq_rsp_t        rsp_q;

	bmhq_ctrl_t ctrl;
	bmhq_slot_t slots [CAPACITY];
	logic       takes [CAPACITY];

	logic      is_full;
	logic      is_empty;
	bmhq_rsp_t rsp_d;

	assign busy = req_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_vld_s1 <= 1'b0;
		end else begin
			req_vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	assign is_full  = (cnt_q == CNT_W'(CAPACITY));
	assign is_empty = (cnt_q == '0);

	always_comb begin
		ctrl.ins   = req_vld_s1 && (req_s1.kind == OP_INSERT) && !is_full;
		ctrl.rem   = req_vld_s1 && (req_s1.kind == OP_REMOVE) && !is_empty;
		ctrl.value = req_s1.value;
	end

	// ---- cell chain --------------------------------------------------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		bmhq_slot_t left_w;
		bmhq_slot_t right_w;
		logic       left_take_w;

		if (i == 0) begin : g_head
			assign left_w      = '0;
			assign left_take_w = 1'b0;
		end else begin : g_body
			assign left_w      = slots[i-1];
			assign left_take_w = takes[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_mid
			assign right_w = slots[i+1];
		end

		bmhq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left      (left_w),
			.left_take (left_take_w),
			.right     (right_w),
			.slot      (slots[i]),
			.take      (takes[i])
		);
	end

	// ---- result ------------------------------------------------------------
	always_comb begin
		rsp_d.status        = ST_DONE;
		rsp_d.removed_value = '0;
		rsp_d.top_value     = slots[0].valid ? slots[0].value : '0;
		rsp_d.entry_count   = ENTRY_W'(cnt_q);
		if (req_s1.kind == OP_INSERT) begin
			if (is_full) begin
				rsp_d.status = ST_FULL;
			end else begin
				rsp_d.top_value   = takes[0] ? req_s1.value : slots[0].value;
				rsp_d.entry_count = ENTRY_W'(cnt_q + 1'b1);
			end
		end else begin
			if (is_empty) begin
				rsp_d.status = ST_EMPTY;
			end else begin
				rsp_d.removed_value = slots[0].value;
				rsp_d.top_value     = slots[1].valid ? slots[1].value : '0;
				rsp_d.entry_count   = ENTRY_W'(cnt_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= req_vld_s1;
			if (ctrl.ins) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (ctrl.rem) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_vld_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

@@ sv/bmhq_cell.sv @@
// ----------------------------------------------------------------------------
// bmhq_cell - one cell of the sorted queue chain
// Holds one entry; shifts right on insert, left on remove.
// ----------------------------------------------------------------------------
module bmhq_cell
	import bmhq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  bmhq_ctrl_t ctrl,
	input  bmhq_slot_t left,       // neighbor toward the maximum
	input  logic       left_take,  // neighbor claims the new value
	input  bmhq_slot_t right,      // neighbor toward the tail
	output bmhq_slot_t slot,
	output logic       take
);

	logic                      valid_q;
	logic signed [VALUE_W-1:0] value_q;
	bmhq_slot_t                slot_d;

	// new value belongs here or earlier: empty cell or strictly smaller entry
	assign take = !valid_q || (value_q < ctrl.value);
	assign slot = '{valid: valid_q, value: value_q};

	always_comb begin
		slot_d = slot;
		if (ctrl.ins) begin
			if (left_take) begin
				slot_d = left;
			end else if (take) begin
				slot_d.valid = 1'b1;
				slot_d.value = ctrl.value;
			end
		end else if (ctrl.rem) begin
			slot_d = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= slot_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= slot_d.value;
	end

endmodule
